>>> hw/rtl/mfvd_pkg.sv
// Shared types and constants for the meter frame voltage decoder.
`default_nettype none

package mfvd_pkg;

  // Frame layout (byte positions within one frame)
  localparam int unsigned IDX_W = 5;
  localparam logic [IDX_W-1:0] FRAME_LEN        = 5'd24;
  localparam logic [IDX_W-1:0] POS_STATUS       = 5'd0;
  localparam logic [IDX_W-1:0] POS_SUM_FIRST    = 5'd2;
  localparam logic [IDX_W-1:0] POS_SUM_LAST     = 5'd22;
  localparam logic [IDX_W-1:0] POS_PARAM_FIRST  = 5'd2;
  localparam logic [IDX_W-1:0] POS_PARAM_LAST   = 5'd4;
  localparam logic [IDX_W-1:0] POS_REG_FIRST    = 5'd5;
  localparam logic [IDX_W-1:0] POS_REG_LAST     = 5'd7;
  localparam logic [IDX_W-1:0] POS_UPDATE       = 5'd20;
  localparam logic [IDX_W-1:0] POS_CHECKSUM     = 5'd23;

  // Status byte acceptance and update flag
  localparam logic [7:0] STAT_REJECT    = 8'hAA;
  localparam logic [7:0] STAT_ACCEPT    = 8'h55;
  localparam logic [7:0] STAT_MASK      = 8'hF9;
  localparam logic [7:0] STAT_MATCH     = 8'hF0;
  localparam int unsigned UPDATE_BIT    = 6;

  localparam logic [7:0] SCALE_RESET    = 8'd3;

  // Result status codes
  localparam logic [2:0] FS_UPDATED   = 3'd0;
  localparam logic [2:0] FS_SHORT     = 3'd1;
  localparam logic [2:0] FS_BAD_SUM   = 3'd2;
  localparam logic [2:0] FS_REJECTED  = 3'd3;
  localparam logic [2:0] FS_NO_UPDATE = 3'd4;
  localparam logic [2:0] FS_ZERO_DIV  = 3'd5;

  // Serial divide / multiply unit
  localparam int unsigned WORD_W    = 24;
  localparam int unsigned VOLT_W    = 16;
  localparam int unsigned SCALE_W   = 8;
  localparam int unsigned DM_CNT_W  = 5;
  localparam logic [DM_CNT_W-1:0] DIV_LAST = 5'd23;
  localparam logic [DM_CNT_W-1:0] MUL_LAST = 5'd7;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_CHECK,
    ST_CALC,
    ST_EMIT
  } top_state_t;

  typedef enum logic [1:0] {
    DM_IDLE,
    DM_DIV,
    DM_MUL
  } dm_state_t;

  typedef struct packed {
    logic              done;
    logic [VOLT_W-1:0] product;
  } mfvd_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/mfvd_divmul.sv
// Bit-serial 24-bit restoring divider followed by a shift-add scale multiply.
`default_nettype none

module mfvd_divmul (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [23:0]               dividend,
  input  wire logic [23:0]               divisor,
  input  wire logic [7:0]                scale,
  output      mfvd_pkg::mfvd_res_t       res
);
  import mfvd_pkg::*;

  dm_state_t             dm_state_r, dm_state_nxt;
  logic [DM_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [WORD_W-1:0]     rem_r, rem_nxt;
  logic [WORD_W-1:0]     qr_r, qr_nxt;
  logic [WORD_W-1:0]     dsr_r, dsr_nxt;
  logic [VOLT_W-1:0]     mcand_r, mcand_nxt;
  logic [SCALE_W-1:0]    mult_r, mult_nxt;
  logic [VOLT_W-1:0]     acc_r, acc_nxt;
  logic [WORD_W:0]       trial;
  logic [WORD_W:0]       diff;

  // one quotient bit per cycle: shift in next dividend bit, trial subtract
  assign trial = {rem_r, qr_r[WORD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    dm_state_nxt = dm_state_r;
    cnt_nxt      = cnt_r;
    done_nxt     = 1'b0;
    rem_nxt      = rem_r;
    qr_nxt       = qr_r;
    dsr_nxt      = dsr_r;
    mcand_nxt    = mcand_r;
    mult_nxt     = mult_r;
    acc_nxt      = acc_r;
    case (dm_state_r)
      DM_IDLE: begin
        if (start) begin
          rem_nxt      = '0;
          qr_nxt       = dividend;
          dsr_nxt      = divisor;
          mult_nxt     = scale;
          cnt_nxt      = DIV_LAST;
          dm_state_nxt = DM_DIV;
        end
      end
      DM_DIV: begin
        if (!diff[WORD_W]) begin
          rem_nxt = diff[WORD_W-1:0];
        end else begin
          rem_nxt = trial[WORD_W-1:0];
        end
        qr_nxt = {qr_r[WORD_W-2:0], !diff[WORD_W]};
        if (cnt_r == '0) begin
          // quotient wraps to 16 bits before scaling
          mcand_nxt    = qr_nxt[VOLT_W-1:0];
          acc_nxt      = '0;
          cnt_nxt      = MUL_LAST;
          dm_state_nxt = DM_MUL;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      DM_MUL: begin
        // scale bits LSB first, product wraps to 16 bits
        if (mult_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt = {mcand_r[VOLT_W-2:0], 1'b0};
        mult_nxt  = {1'b0, mult_r[SCALE_W-1:1]};
        if (cnt_r == '0) begin
          done_nxt     = 1'b1;
          dm_state_nxt = DM_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        dm_state_nxt = DM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dm_state_r <= DM_IDLE;
      cnt_r      <= '0;
      done_r     <= 1'b0;
    end else begin
      dm_state_r <= dm_state_nxt;
      cnt_r      <= cnt_nxt;
      done_r     <= done_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    qr_r    <= qr_nxt;
    dsr_r   <= dsr_nxt;
    mcand_r <= mcand_nxt;
    mult_r  <= mult_nxt;
    acc_r   <= acc_nxt;
  end

  assign res.done    = done_r;
  assign res.product = acc_r;

endmodule

`default_nettype wire

>>> hw/rtl/meter_frame_voltage_decoder.sv
// Top level: frame byte capture, frame checks and voltage result register.
//
//   channel  | ports                                   | dir
//   ---------+-----------------------------------------+-----
//   in       | in_valid in_ready in_rx_byte in_frame_end | in
//   out      | out_valid out_ready out_voltage out_frame_status | out
//   cfg      | cfg_wr_en cfg_wr_data (voltage_scale)   | in
//
// Each byte is taken in a cycle with in_valid and in_ready both high. The result of
// a frame that is not updated is loaded from the check state; an updated frame goes
// through the check state, the serial divider, the serial scale multiplier and emit.
// in_ready is low from a frame-end transaction until its result is loaded
// into the output register; a pending result blocks only the next result.
// Reset is synchronous, active low; stored voltage clears, scale becomes 3.
`default_nettype none

module meter_frame_voltage_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_frame_end,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [15:0] out_voltage,
  output      logic [2:0]  out_frame_status,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);
  import mfvd_pkg::*;

  top_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [7:0]          sum_r, sum_nxt;
  logic [7:0]          stat_r, stat_nxt;
  logic [WORD_W-1:0]   param_r, param_nxt;
  logic [WORD_W-1:0]   vreg_r, vreg_nxt;
  logic [7:0]          upd_r, upd_nxt;
  logic [7:0]          chk_r, chk_nxt;
  logic [VOLT_W-1:0]   voltage_r, voltage_nxt;
  logic [7:0]          scale_r;
  logic                out_valid_r, out_valid_nxt;
  logic [VOLT_W-1:0]   out_voltage_r, out_voltage_nxt;
  logic [2:0]          out_status_r, out_status_nxt;
  logic [2:0]          chk_code;
  logic                stat_ok;
  logic                slot_free;
  logic                dm_start;
  mfvd_res_t           dm_res;

  mfvd_divmul u_divmul (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dm_start),
    .dividend (param_r),
    .divisor  (vreg_r),
    .scale    (scale_r),
    .res      (dm_res)
  );

  assign slot_free = !out_valid_r || out_ready;

  // frame checks, first failure wins
  assign stat_ok = (stat_r != STAT_REJECT) &&
                   ((stat_r == STAT_ACCEPT) || ((stat_r & STAT_MASK) == STAT_MATCH));

  always_comb begin
    if (idx_r < FRAME_LEN) begin
      chk_code = FS_SHORT;
    end else if (sum_r != chk_r) begin
      chk_code = FS_BAD_SUM;
    end else if (!stat_ok) begin
      chk_code = FS_REJECTED;
    end else if (!upd_r[UPDATE_BIT]) begin
      chk_code = FS_NO_UPDATE;
    end else if (vreg_r == '0) begin
      chk_code = FS_ZERO_DIV;
    end else begin
      chk_code = FS_UPDATED;
    end
  end

  // next state, byte capture and result loading
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    sum_nxt         = sum_r;
    stat_nxt        = stat_r;
    param_nxt       = param_r;
    vreg_nxt        = vreg_r;
    upd_nxt         = upd_r;
    chk_nxt         = chk_r;
    voltage_nxt     = voltage_r;
    out_voltage_nxt = out_voltage_r;
    out_status_nxt  = out_status_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    in_ready        = 1'b0;
    dm_start        = 1'b0;
    case (state_r)
      ST_RECV: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // bytes past the frame length are dropped
          if (idx_r < FRAME_LEN) begin
            idx_nxt = idx_r + 1'b1;
            if (idx_r >= POS_SUM_FIRST && idx_r <= POS_SUM_LAST) begin
              sum_nxt = sum_r + in_rx_byte;
            end
            case (idx_r) inside
              POS_STATUS: begin
                stat_nxt = in_rx_byte;
              end
              [POS_PARAM_FIRST:POS_PARAM_LAST]: begin
                param_nxt = {param_r[WORD_W-9:0], in_rx_byte};
              end
              [POS_REG_FIRST:POS_REG_LAST]: begin
                vreg_nxt = {vreg_r[WORD_W-9:0], in_rx_byte};
              end
              POS_UPDATE: begin
                upd_nxt = in_rx_byte;
              end
              POS_CHECKSUM: begin
                chk_nxt = in_rx_byte;
              end
              default: begin
              end
            endcase
          end
          if (in_frame_end) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (chk_code == FS_UPDATED) begin
          dm_start  = 1'b1;
          idx_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = ST_CALC;
        end else if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_voltage_nxt = voltage_r;
          out_status_nxt  = chk_code;
          idx_nxt         = '0;
          sum_nxt         = '0;
          state_nxt       = ST_RECV;
        end
      end
      ST_CALC: begin
        if (dm_res.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          voltage_nxt     = dm_res.product;
          out_valid_nxt   = 1'b1;
          out_voltage_nxt = dm_res.product;
          out_status_nxt  = FS_UPDATED;
          state_nxt       = ST_RECV;
        end
      end
      default: begin
        state_nxt = ST_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RECV;
      idx_r       <= '0;
      sum_r       <= '0;
      voltage_r   <= '0;
      scale_r     <= SCALE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      voltage_r   <= voltage_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        scale_r <= cfg_wr_data;
      end
    end
  end

  // captured frame bytes and result payload
  always_ff @(posedge clk) begin
    stat_r        <= stat_nxt;
    param_r       <= param_nxt;
    vreg_r        <= vreg_nxt;
    upd_r         <= upd_nxt;
    chk_r         <= chk_nxt;
    out_voltage_r <= out_voltage_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_voltage      = out_voltage_r;
  assign out_frame_status = out_status_r;

`ifndef SYNTH
  // a pending result always shows the stored voltage
  a_out_matches_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_voltage_r == voltage_r))
    else $error("pending result voltage differs from stored voltage");

  // byte counter saturates at the frame length
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= FRAME_LEN)
    else $error("byte index past frame length");

  // serial unit finishes only while a calculation is pending
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    dm_res.done |-> (state_r == ST_CALC))
    else $error("divide/multiply done outside calculation");

  // a frame-end transaction closes the input until its result is loaded
  a_end_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_frame_end) |=> !in_ready)
    else $error("input accepted right after frame end");

  // an update result is only loaded from the serial unit's product
  a_update_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !out_valid_r && (out_status_nxt == FS_UPDATED)) |->
      (state_r == ST_EMIT))
    else $error("update status loaded outside emit");
`endif

endmodule

`default_nettype wire

>>> sim/meter_frame_voltage_decoder_tb.sv
// Self-checking testbench for the meter frame voltage decoder.
`timescale 1ns / 1ps

module meter_frame_voltage_decoder_tb;
  import mfvd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 45;
  localparam int RANDOM_BYTES  = 2000;

  typedef struct packed {
    logic [15:0] voltage;
    logic [2:0]  status;
  } frame_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        in_frame_end;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_voltage;
  logic [2:0]  out_frame_status;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  // Decoder model state
  logic [4:0]  model_index;
  logic [7:0]  model_sum;
  logic [7:0]  model_status_byte;
  logic [23:0] model_param;
  logic [23:0] model_divisor;
  logic [7:0]  model_update;
  logic [7:0]  model_checksum;
  logic [15:0] model_voltage;
  logic [7:0]  model_scale;

  frame_result_t pending_results[$];

  // Frame under construction by the stimulus
  logic [7:0] frame_buf [24];

  int  cycle_count;
  int  error_count;
  int  bytes_sent;
  int  frames_seen;
  int  scale_writes;
  int  status_count [6];
  bit  idle_on;
  int  hold_request;
  int  longest_hold;

  meter_frame_voltage_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_frame_end     (in_frame_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_voltage      (out_voltage),
    .out_frame_status (out_frame_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic bit status_accepted(input logic [7:0] stat);
    return (stat != STAT_REJECT) &&
           ((stat == STAT_ACCEPT) || ((stat & STAT_MASK) == STAT_MATCH));
  endfunction

  // Advance the decoder model by one byte; queue a result on frame end
  task automatic decode_frame_byte(input logic [7:0] b, input logic last);
    frame_result_t r;
    logic [23:0]   quotient;
    logic [23:0]   product;
    if (model_index < FRAME_LEN) begin
      if (model_index >= POS_SUM_FIRST && model_index <= POS_SUM_LAST)
        model_sum = model_sum + b;
      if (model_index == POS_STATUS)
        model_status_byte = b;
      else if (model_index >= POS_PARAM_FIRST && model_index <= POS_PARAM_LAST)
        model_param = {model_param[15:0], b};
      else if (model_index >= POS_REG_FIRST && model_index <= POS_REG_LAST)
        model_divisor = {model_divisor[15:0], b};
      else if (model_index == POS_UPDATE)
        model_update = b;
      else if (model_index == POS_CHECKSUM)
        model_checksum = b;
      model_index = model_index + 1'b1;
    end
    if (last) begin
      // checks in priority order; first failure wins
      if (model_index < FRAME_LEN)
        r.status = FS_SHORT;
      else if (model_sum != model_checksum)
        r.status = FS_BAD_SUM;
      else if (!status_accepted(model_status_byte))
        r.status = FS_REJECTED;
      else if (!model_update[UPDATE_BIT])
        r.status = FS_NO_UPDATE;
      else if (model_divisor == '0)
        r.status = FS_ZERO_DIV;
      else begin
        r.status      = FS_UPDATED;
        quotient      = model_param / model_divisor;
        product       = quotient[15:0] * model_scale;
        model_voltage = product[15:0];
      end
      r.voltage = model_voltage;
      pending_results.push_back(r);
      model_index = '0;
      model_sum   = '0;
    end
  endtask

  // Result check first, then model update for the accepted byte
  always @(posedge clk) begin : scoreboard
    frame_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        frames_seen++;
        if (out_frame_status <= FS_ZERO_DIV)
          status_count[out_frame_status]++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got voltage %0d status %0d",
                   $time, out_voltage, out_frame_status);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_voltage !== want.voltage) begin
            $display("%0t: voltage mismatch, expected %0d, got %0d",
                     $time, want.voltage, out_voltage);
            error_count++;
          end
          if (out_frame_status !== want.status) begin
            $display("%0t: frame status mismatch, expected %0d, got %0d",
                     $time, want.status, out_frame_status);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready)
        decode_frame_byte(in_rx_byte, in_frame_end);
    end
  end

  // Result receiver: random idling plus requested long hold-offs
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (idle_on && $urandom_range(99) < 9)
        out_ready <= 1'b0;
      else
        out_ready <= 1'b1;
    end
  end

  // One byte transaction; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_rx_byte   <= b;
    in_frame_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Lay out a frame with a correct checksum
  task automatic fill_frame(input logic [7:0] stat, input logic [23:0] param,
                            input logic [23:0] divr, input logic [7:0] upd);
    int i;
    logic [7:0] sum;
    for (i = 0; i < 24; i++) frame_buf[i] = 8'($urandom_range(255));
    frame_buf[POS_STATUS] = stat;
    {frame_buf[2], frame_buf[3], frame_buf[4]} = param;
    {frame_buf[5], frame_buf[6], frame_buf[7]} = divr;
    frame_buf[POS_UPDATE] = upd;
    sum = '0;
    for (i = POS_SUM_FIRST; i <= POS_SUM_LAST; i++) sum = sum + frame_buf[i];
    frame_buf[POS_CHECKSUM] = sum;
  endtask

  // Send len bytes of the frame buffer, random bytes past the 24th
  task automatic send_frame(input int len);
    int i;
    for (i = 0; i < len; i++)
      send_byte((i < 24) ? frame_buf[i] : 8'($urandom_range(255)), i == len - 1);
  endtask

  // Input goes quiet, then wait for every result and a settle time
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Scale write while the decoder is idle
  task automatic write_scale(input logic [7:0] value);
    wait_idle();
    in_valid    <= 1'b0;
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    model_scale = value;
    scale_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] good_status();
    if ($urandom_range(4) == 0) return STAT_ACCEPT;
    return STAT_MATCH | 8'($urandom_range(3) << 1);
  endfunction

  function automatic logic [7:0] bad_status();
    logic [7:0] s;
    if ($urandom_range(3) == 0) return STAT_REJECT;
    do s = 8'($urandom_range(255)); while (status_accepted(s));
    return s;
  endfunction

  function automatic logic [23:0] any_divisor();
    case ($urandom_range(3))
      0:       return 24'($urandom_range(1, 15));
      1:       return 24'($urandom_range(1, 255));
      2:       return 24'($urandom_range(1, 65535));
      default: return 24'($urandom_range(1, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [7:0] update_set();
    return 8'($urandom_range(255)) | (8'd1 << UPDATE_BIT);
  endfunction

  function automatic logic [23:0] any_param();
    return 24'($urandom_range(24'hFFFFFF));
  endfunction

  // Good frames under the reset scale
  task automatic test_reset_scale_update();
    fill_frame(STAT_ACCEPT, 24'd1000, 24'd7, 8'h40);
    send_frame(24);
    fill_frame(8'hF6, 24'hFFFFFF, 24'd300, 8'hFF);
    send_frame(24);
  endtask

  // Checksum, status, update and divisor checks in turn, and combined failures to prove priority
  task automatic test_check_order();
    fill_frame(STAT_REJECT, 24'd500, 24'd5, 8'h40);
    frame_buf[POS_CHECKSUM] = ~frame_buf[POS_CHECKSUM];
    send_frame(24);                                   // bad sum beats bad status
    fill_frame(STAT_REJECT, 24'd500, 24'd0, 8'h00);
    send_frame(24);                                   // status rejected
    fill_frame(8'hF8, 24'd500, 24'd5, 8'hFF);
    send_frame(24);                                   // fails the mask match
    fill_frame(8'hF2, 24'd500, 24'd0, 8'hBF);
    send_frame(24);                                   // update bit missing
    fill_frame(8'hF4, 24'd500, 24'd0, 8'h40);
    send_frame(24);                                   // zero divisor, voltage kept
  endtask

  // Short, single-byte and over-long frames
  task automatic test_frame_length();
    fill_frame(STAT_ACCEPT, 24'd9000, 24'd3, 8'h40);
    send_frame(1);
    send_frame(23);
    send_frame(27);                                   // extra bytes are dropped
  endtask

  // Field extremes and scale extremes, quotient and product wrap
  task automatic test_field_extremes();
    write_scale(8'd255);
    fill_frame(8'hF0, 24'hFFFFFF, 24'd1, 8'h40);
    send_frame(24);
    fill_frame(STAT_ACCEPT, 24'd0, 24'hFFFFFF, 8'h7F);
    send_frame(24);
    write_scale(8'd0);
    fill_frame(STAT_ACCEPT, 24'd123456, 24'd11, 8'hC0);
    send_frame(24);
    write_scale(8'd1);
    fill_frame(8'hFF, 24'd77, 24'd1, 8'hFF);
    send_frame(24);
  endtask

  // Receiver held off long enough that the input side must stall
  task automatic test_backpressure();
    int n;
    wait_idle();
    hold_request = 300;
    if (300 > longest_hold) longest_hold = 300;
    for (n = 0; n < 6; n++) begin
      fill_frame(good_status(), any_param(), any_divisor(), update_set());
      send_frame((n % 2) ? 24 : $urandom_range(1, 3));
    end
  endtask

  // Mostly well-formed frames with random content, some broken ones and noise
  task automatic test_random_frames();
    int start;
    int kind;
    int next_scale_at;
    int i;
    start         = bytes_sent;
    next_scale_at = bytes_sent + 400;
    idle_on       = 1'b0;                             // opening stretch at full rate
    while (bytes_sent < start + RANDOM_BYTES) begin
      if (bytes_sent > start + RANDOM_BYTES / 4) idle_on = 1'b1;
      if (bytes_sent >= next_scale_at) begin
        write_scale($urandom_range(3) == 0 ? 8'($urandom_range(1) * 255)
                                           : 8'($urandom_range(255)));
        next_scale_at = bytes_sent + 400;
      end
      kind = $urandom_range(99);
      fill_frame(good_status(), any_param(), any_divisor(), update_set());
      if (kind < 55)
        send_frame(24);
      else if (kind < 63) begin
        frame_buf[POS_CHECKSUM] = frame_buf[POS_CHECKSUM] ^ 8'($urandom_range(1, 255));
        send_frame(24);
      end else if (kind < 71) begin
        fill_frame(bad_status(), any_param(), any_divisor(), update_set());
        send_frame(24);
      end else if (kind < 78) begin
        fill_frame(good_status(), any_param(), any_divisor(),
                   update_set() & ~(8'd1 << UPDATE_BIT));
        send_frame(24);
      end else if (kind < 83) begin
        fill_frame(good_status(), any_param(), 24'd0, update_set());
        send_frame(24);
      end else if (kind < 91)
        send_frame($urandom_range(1, 23));
      else if (kind < 96)
        send_frame($urandom_range(25, 30));
      else begin
        for (i = 0; i < 24; i++) frame_buf[i] = 8'($urandom_range(255));
        send_frame($urandom_range(1, 26));
      end
    end
  endtask

  // Test sequence
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_rx_byte   = '0;
    in_frame_end = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    cycle_count  = 0;
    error_count  = 0;
    bytes_sent   = 0;
    frames_seen  = 0;
    scale_writes = 0;
    hold_request = 0;
    longest_hold = 0;
    idle_on      = 1'b1;
    foreach (status_count[i]) status_count[i] = 0;
    model_index       = '0;
    model_sum         = '0;
    model_status_byte = '0;
    model_param       = '0;
    model_divisor     = '0;
    model_update      = '0;
    model_checksum    = '0;
    model_voltage     = '0;
    model_scale       = SCALE_RESET;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_scale_update();
    test_check_order();
    test_frame_length();
    test_field_extremes();
    test_backpressure();
    test_random_frames();

    wait_idle();

    $display("Covered %0d bytes in %0d frames: %0d updated, %0d short, %0d bad sum,",
             bytes_sent, frames_seen, status_count[FS_UPDATED], status_count[FS_SHORT],
             status_count[FS_BAD_SUM]);
    $display("%0d rejected, %0d without update, %0d zero divisor; %0d scale writes, %0d-cycle hold",
             status_count[FS_REJECTED], status_count[FS_NO_UPDATE],
             status_count[FS_ZERO_DIV], scale_writes, longest_hold);
    if (error_count == 0 && pending_results.size() == 0)
      $display("TEST PASSED");
    else begin
      if (pending_results.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/mfvd_pkg.sv
hw/rtl/mfvd_divmul.sv
hw/rtl/meter_frame_voltage_decoder.sv
sim/meter_frame_voltage_decoder_tb.sv
